@@ hw/rtl/tgv_pkg.sv @@
// Shared constants and types of the triangle grid vertex generator.
package tgv_pkg;
    localparam int COORD_W   = 32;
    localparam int ROW_W     = 6;
    localparam int MAX_ROWS  = 63;
    localparam int NUM_W     = COORD_W + ROW_W + 2;
    localparam int DIV_STEPS = NUM_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int AXES      = 3;

    typedef logic signed [COORD_W-1:0] t_crd;

    typedef struct packed {
        t_crd             corner_a_x;
        t_crd             corner_a_y;
        t_crd             corner_a_z;
        t_crd             corner_b_x;
        t_crd             corner_b_y;
        t_crd             corner_b_z;
        t_crd             corner_c_x;
        t_crd             corner_c_y;
        t_crd             corner_c_z;
        logic [ROW_W-1:0] row_number;
    } t_in_pl;

    typedef struct packed {
        t_crd             vertex_x;
        t_crd             vertex_y;
        t_crd             vertex_z;
        logic [ROW_W-1:0] column_number;
        logic             last_in_row;
    } t_out_pl;

    typedef struct packed {
        logic             load;
        logic             mul;
        logic             div_start;
        logic             div_step;
        logic             out_load;
        logic             acc_step;
        logic [ROW_W-1:0] col;
        logic             last;
    } t_cmd;

    typedef struct packed {
        logic [ROW_W-1:0] row_i;
    } t_sts;
endpackage

@@ hw/rtl/tgv_if.sv @@
// Item channels of the triangle grid vertex generator.
interface tgv_in_if import tgv_pkg::*;;
    logic             valid;
    logic             ready;
    t_crd             corner_a_x;
    t_crd             corner_a_y;
    t_crd             corner_a_z;
    t_crd             corner_b_x;
    t_crd             corner_b_y;
    t_crd             corner_b_z;
    t_crd             corner_c_x;
    t_crd             corner_c_y;
    t_crd             corner_c_z;
    logic [ROW_W-1:0] row_number;
    modport source (output valid, corner_a_x, corner_a_y, corner_a_z, corner_b_x, corner_b_y,
                    corner_b_z, corner_c_x, corner_c_y, corner_c_z, row_number,
                    input ready);
    modport sink (input valid, corner_a_x, corner_a_y, corner_a_z, corner_b_x, corner_b_y,
                  corner_b_z, corner_c_x, corner_c_y, corner_c_z, row_number,
                  output ready);
endinterface

interface tgv_out_if import tgv_pkg::*;;
    logic             valid;
    logic             ready;
    t_crd             vertex_x;
    t_crd             vertex_y;
    t_crd             vertex_z;
    logic [ROW_W-1:0] column_number;
    logic             last_in_row;
    modport source (output valid, vertex_x, vertex_y, vertex_z, column_number, last_in_row,
                    input ready);
    modport sink (input valid, vertex_x, vertex_y, vertex_z, column_number, last_in_row,
                  output ready);
endinterface

@@ hw/rtl/triangle_grid_vertex_generator_top.sv @@
// Top level of the triangle grid vertex generator.
//
//  channel | dir | handshake     | payload
//  i_in    | in  | valid/ready   | corners a, b, c (Q16.16 x/y/z), row_number
//  o_out   | out | valid/ready   | vertex x/y/z, column_number, last_in_row
//  cfg     | in  | i_cfg_we      | i_cfg_data = row_count
//
// Each vertex of a row item runs a 40-step restoring division by the row count
// in three parallel serial dividers.
// One item is in work at a time; ready is high only while idle.
// Reset is synchronous, active low; row_count resets to 8.
// An output stall holds the vertex in the output register and pauses the sequencer.
module triangle_grid_vertex_generator_top import tgv_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [ROW_W-1:0] i_cfg_data,
    tgv_in_if.sink           i_in,
    tgv_out_if.source        o_out
);
    t_cmd    w_cmd;
    t_sts    w_sts;
    t_in_pl  w_in;
    t_out_pl w_out;

    assign w_in.corner_a_x = i_in.corner_a_x;
    assign w_in.corner_a_y = i_in.corner_a_y;
    assign w_in.corner_a_z = i_in.corner_a_z;
    assign w_in.corner_b_x = i_in.corner_b_x;
    assign w_in.corner_b_y = i_in.corner_b_y;
    assign w_in.corner_b_z = i_in.corner_b_z;
    assign w_in.corner_c_x = i_in.corner_c_x;
    assign w_in.corner_c_y = i_in.corner_c_y;
    assign w_in.corner_c_z = i_in.corner_c_z;
    assign w_in.row_number = i_in.row_number;

    tgv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    tgv_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (w_in),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_out      (w_out)
    );

    assign o_out.vertex_x      = w_out.vertex_x;
    assign o_out.vertex_y      = w_out.vertex_y;
    assign o_out.vertex_z      = w_out.vertex_z;
    assign o_out.column_number = w_out.column_number;
    assign o_out.last_in_row   = w_out.last_in_row;

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input ready while a vertex is pending");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("ready stayed high after an accepted item");

    a_last_column: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.last_in_row) |-> (o_out.column_number == w_sts.row_i))
        else $error("last vertex not at the saturated row column");
endmodule

@@ hw/rtl/tgv_ctrl.sv @@
// Sequencer of the triangle grid vertex generator.
module tgv_ctrl import tgv_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DST  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [ROW_W-1:0] r_col, n_col;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_col   = r_col;
        o_cmd   = '0;
        o_cmd.col  = r_col;
        o_cmd.last = (r_col == i_sts.row_i);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_col      = '0;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DST;
            end
            S_DST: begin
                o_cmd.div_start = 1'b1;
                n_cnt           = '0;
                n_state         = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.out_load = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    if (r_col == i_sts.row_i) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.acc_step = 1'b1;
                        n_col          = r_col + 1'b1;
                        n_state        = S_DST;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_col   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_col   <= n_col;
        end
    end
endmodule

@@ hw/rtl/tgv_dp.sv @@
// Datapath of the triangle grid vertex generator: setup, serial dividers, output register.
module tgv_dp import tgv_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [ROW_W-1:0] i_cfg_data,
    input  t_in_pl           i_in,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    output t_out_pl          o_out
);
    logic [ROW_W-1:0]        r_row_count;
    logic [ROW_W-1:0]        r_i, r_n;
    logic [ROW_W-1:0]        w_n_eff;
    t_crd                    w_a [AXES];
    t_crd                    w_b [AXES];
    t_crd                    w_c [AXES];
    t_crd                    r_a [AXES];
    logic signed [COORD_W:0] r_d [AXES];
    logic signed [COORD_W:0] r_e [AXES];
    logic signed [NUM_W-1:0] r_acc [AXES];
    logic [NUM_W-1:0]        r_div [AXES];
    logic [ROW_W-1:0]        r_rem [AXES];
    logic                    r_neg [AXES];
    logic [ROW_W:0]          w_t [AXES];
    logic                    w_ge [AXES];
    logic [NUM_W-1:0]        w_qs [AXES];
    t_crd                    w_v [AXES];
    t_out_pl                 r_out;

    assign w_a[0] = i_in.corner_a_x;
    assign w_a[1] = i_in.corner_a_y;
    assign w_a[2] = i_in.corner_a_z;
    assign w_b[0] = i_in.corner_b_x;
    assign w_b[1] = i_in.corner_b_y;
    assign w_b[2] = i_in.corner_b_z;
    assign w_c[0] = i_in.corner_c_x;
    assign w_c[1] = i_in.corner_c_y;
    assign w_c[2] = i_in.corner_c_z;

    assign w_n_eff = (r_row_count == '0) ? ROW_W'(1) : r_row_count;

    always_comb begin
        for (int k = 0; k < AXES; k++) begin
            w_t[k]  = {r_rem[k], r_div[k][NUM_W-1]};
            w_ge[k] = (w_t[k] >= {1'b0, r_n});
            w_qs[k] = r_neg[k] ? (~r_div[k] + NUM_W'(r_rem[k] == '0)) : r_div[k];
            w_v[k]  = r_a[k] + t_crd'(w_qs[k][COORD_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= ROW_W'(8);
        end else if (i_cfg_we) begin
            r_row_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n <= w_n_eff;
            r_i <= (i_in.row_number > w_n_eff) ? w_n_eff : i_in.row_number;
        end
        for (int k = 0; k < AXES; k++) begin
            if (i_cmd.load) begin
                r_a[k] <= w_a[k];
                r_d[k] <= (COORD_W+1)'(w_b[k]) - (COORD_W+1)'(w_a[k]);
                r_e[k] <= (COORD_W+1)'(w_c[k]) - (COORD_W+1)'(w_b[k]);
            end
            if (i_cmd.mul) begin
                r_acc[k] <= NUM_W'(r_d[k]) * NUM_W'($signed({1'b0, r_i}));
            end else if (i_cmd.acc_step) begin
                r_acc[k] <= r_acc[k] + NUM_W'(r_e[k]);
            end
            if (i_cmd.div_start) begin
                r_neg[k] <= r_acc[k][NUM_W-1];
                r_div[k] <= r_acc[k][NUM_W-1] ? NUM_W'(-r_acc[k]) : NUM_W'(r_acc[k]);
                r_rem[k] <= '0;
            end else if (i_cmd.div_step) begin
                r_rem[k] <= w_ge[k] ? ROW_W'(w_t[k] - {1'b0, r_n}) : w_t[k][ROW_W-1:0];
                r_div[k] <= {r_div[k][NUM_W-2:0], w_ge[k]};
            end
        end
        if (i_cmd.out_load) begin
            r_out.vertex_x      <= w_v[0];
            r_out.vertex_y      <= w_v[1];
            r_out.vertex_z      <= w_v[2];
            r_out.column_number <= i_cmd.col;
            r_out.last_in_row   <= i_cmd.last;
        end
    end

    assign o_sts.row_i = r_i;
    assign o_out       = r_out;
endmodule
